/* design/image_convolution_replicate_border_top_assert.svh */
// Assertion macros for the replicated-border convolution block.
// Used by modules that check their own logic; needs clk_i and rst_ni in scope.
`ifndef IMAGE_CONVOLUTION_REPLICATE_BORDER_TOP_ASSERT_SVH
`define IMAGE_CONVOLUTION_REPLICATE_BORDER_TOP_ASSERT_SVH

// same-cycle implication
`define ICRB_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("icrb assertion failed");

// next-cycle implication
`define ICRB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("icrb assertion failed");

`endif

/* design/icrb_pkg.sv */
// Shared types and codes for the replicated-border convolution block.
// No dependencies.
package icrb_pkg;

  localparam logic [1:0] CMD_COEF  = 2'd0;
  localparam logic [1:0] CMD_PIXEL = 2'd1;
  localparam logic [1:0] CMD_DRAIN = 2'd2;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_RADIUS = 2'd2;

  typedef enum logic [1:0] {
    KIND_COEF,
    KIND_PIXEL,
    KIND_DRAIN,
    KIND_NOP
  } icrb_kind_e;

  typedef struct packed {
    icrb_kind_e         kind;
    logic [7:0]         pixel;
    logic [5:0]         coef_idx;
    logic signed [15:0] coef_val;
  } icrb_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MAC,
    ST_DRAIN,
    ST_RESULT
  } icrb_state_e;

endpackage

/* design/image_convolution_replicate_border_top.sv */
// Streaming 2-D convolution with replicated borders, top level.
// Usage:
//   s_axis carries one item per transfer: tuser is the command (load coefficient,
//   pixel, drain, no-op); tdata holds pixel, coefficient index and value.
//   m_axis carries one result per transfer: tdata holds the saturated sum and the
//   output position, tlast marks the last pixel of a frame, tuser the clip flag.
//   cfg_we_i/cfg_index_i/cfg_data_i write width, height and radius; a write
//   restarts the stream and keeps the coefficients. Write only while idle.
// Sequence:
//   Every item is popped in the idle state; pixel and drain items then get a
//   window check. An emitting item runs pop, window check, one tap per
//   cycle through a single multiplier and one line-store read port, a flush
//   of the read/multiply pipe, and a load of the output register.
//   A 2-entry queue behind s_axis keeps accepting while the back end works.
// Reset: positions clear, width 640, height 480, radius 1; stores are undefined.
// Stall: a held result stays in the output register; the back end waits, and
//   s_axis deasserts tready once the queue is full.
// Depends on icrb_pkg, icrb_front, icrb_back.
module image_convolution_replicate_border_top import icrb_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_RADIUS = 3,
  parameter int COEF_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // pixel_value, coef_index, coef_value, pad
  input  logic [1:0]  s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // filtered_value, out_column, out_row, pad
  output logic        m_axis_tlast,   // frame_last
  output logic        m_axis_tuser    // saturated
);

  logic       q_valid, q_pop;
  icrb_item_t q_item;

  icrb_front #(
    .MAX_RADIUS (MAX_RADIUS),
    .COEF_BITS  (COEF_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid_o     (q_valid),
    .q_item_o      (q_item),
    .q_pop_i       (q_pop)
  );

  icrb_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS),
    .COEF_BITS  (COEF_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

/* design/icrb_front.sv */
// Front end: takes input transfers, classifies them and queues them (2 entries).
// Depends on icrb_pkg.
module icrb_front import icrb_pkg::*; #(
  parameter int MAX_RADIUS = 3,
  parameter int COEF_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // pixel_value, coef_index, coef_value, pad
  input  logic [1:0]  s_axis_tuser,   // command
  output logic        q_valid_o,
  output icrb_item_t  q_item_o,
  input  logic        q_pop_i
);

  localparam int KCOUNT = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int CHI    = (1 << (COEF_BITS - 1)) - 1;
  localparam int CLO    = -CHI - 1;

  icrb_item_t item_in;
  icrb_item_t q_mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  int         cv;

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid_o     = (cnt_q != 2'd0);
  assign q_item_o      = q_mem_q[rd_ptr_q];

  always_comb begin
    cv = 32'(signed'(s_axis_tdata[29:14]));
    item_in.pixel    = s_axis_tdata[7:0];
    item_in.coef_idx = s_axis_tdata[13:8];
    if (cv > CHI) begin
      cv = CHI;
    end else if (cv < CLO) begin
      cv = CLO;
    end
    item_in.coef_val = 16'(cv);
    case (s_axis_tuser)
      CMD_COEF: begin
        // loads beyond the largest kernel are dropped
        item_in.kind = (32'(s_axis_tdata[13:8]) < KCOUNT) ? KIND_COEF : KIND_NOP;
      end
      CMD_PIXEL: item_in.kind = KIND_PIXEL;
      CMD_DRAIN: item_in.kind = KIND_DRAIN;
      default:   item_in.kind = KIND_NOP;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

endmodule

/* design/icrb_back.sv */
// Back end: line store, coefficient store, position tracking and the serial
// multiply-accumulate over the clamped window; holds the output register.
// Depends on icrb_pkg and the assertion macro header.
`include "image_convolution_replicate_border_top_assert.svh"
module icrb_back import icrb_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_RADIUS = 3,
  parameter int COEF_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        q_valid_i,
  input  icrb_item_t  q_item_i,
  output logic        q_pop_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tlast,
  output logic        m_axis_tuser
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int WW   = CW + 1;
  localparam int HW   = RW + 1;
  localparam int RDW  = $clog2(MAX_RADIUS + 1);
  localparam int KW   = $clog2(2 * MAX_RADIUS + 1);
  localparam int LR   = 2 * MAX_RADIUS + 2;
  localparam int SW   = $clog2(LR);
  localparam int KCOUNT = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int KIW  = $clog2(KCOUNT);
  localparam int XW   = ((CW > KW) ? CW : KW) + 2;
  localparam int YW   = ((RW > KW) ? RW : KW) + 2;
  localparam int PW   = 9 + COEF_BITS;
  localparam int ACC_RAW = PW + KIW;
  localparam int ACC_W = (ACC_RAW > 33) ? ACC_RAW : 33;
  localparam int W_RST = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;
  localparam int H_RST = (MAX_HEIGHT < 480) ? MAX_HEIGHT : 480;
  localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-32){1'b0}}, 32'h7fffffff};
  localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-32){1'b1}}, 32'h80000000};

  // configuration (effective values)
  logic [WW-1:0]  width_q;
  logic [HW-1:0]  height_q;
  logic [RDW-1:0] rad_q;

  // stream position
  logic [CW-1:0] in_col_q, pend_col_q;
  logic [RW-1:0] in_row_q, pend_row_q;
  logic [SW-1:0] in_slot_q, pend_slot_q;
  logic          frame_rcv_q;

  icrb_state_e state_q, state_d;

  logic [KW-1:0]  ky_q, kx_q;
  logic [KIW-1:0] cidx_q;

  logic [7:0]                  line_mem [LR * (2 ** CW)];
  logic signed [COEF_BITS-1:0] coef_mem [KCOUNT];
  logic [7:0]                  line_rd_q;
  logic signed [COEF_BITS-1:0] coef_rd_q;
  logic                        rd_v_q, prod_v_q;
  logic signed [PW-1:0]        prod_q;
  logic signed [ACC_W-1:0]     acc_q;

  logic out_free, ready, last_tap, do_pixel, start_mac, tap_issue, load_out, is_last;
  logic [WW-1:0] w_m1;
  logic [HW-1:0] h_m1;
  logic [HW-1:0] need_row;
  logic [WW-1:0] need_col;
  logic [XW-1:0] tx;
  logic [YW-1:0] ty, dy, sy;
  logic [CW-1:0] px;
  logic [RW-1:0] py;
  logic [SW-1:0] rd_slot;
  logic [KW-1:0] side_m1;
  logic signed [31:0] sat_val;
  logic               sat_flag;

  assign w_m1     = width_q - WW'(1);
  assign h_m1     = height_q - HW'(1);
  assign side_m1  = KW'({rad_q, 1'b0});
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign last_tap = (ky_q == side_m1) && (kx_q == side_m1);
  assign is_last  = ({1'b0, pend_row_q} == h_m1) && ({1'b0, pend_col_q} == w_m1);

  always_comb begin
    need_row = {1'b0, pend_row_q} + HW'(rad_q);
    if (need_row > h_m1) need_row = h_m1;
    need_col = {1'b0, pend_col_q} + WW'(rad_q);
    if (need_col > w_m1) need_col = w_m1;
    ready = frame_rcv_q || ({1'b0, in_row_q} > need_row) ||
            (({1'b0, in_row_q} == need_row) && ({1'b0, in_col_q} > need_col));
  end

  // clamped window coordinates for the current tap
  always_comb begin
    tx = XW'(pend_col_q) + XW'(kx_q) - XW'(rad_q);
    if (tx[XW-1]) begin
      px = '0;
    end else if (tx >= XW'(width_q)) begin
      px = CW'(w_m1);
    end else begin
      px = CW'(tx);
    end
    ty = YW'(pend_row_q) + YW'(ky_q) - YW'(rad_q);
    if (ty[YW-1]) begin
      py = '0;
    end else if (ty >= YW'(height_q)) begin
      py = RW'(h_m1);
    end else begin
      py = RW'(ty);
    end
    dy = YW'(py) - YW'(pend_row_q);
    sy = YW'(pend_slot_q) + dy;
    if (sy[YW-1]) begin
      sy = sy + YW'(LR);
    end else if (sy >= YW'(LR)) begin
      sy = sy - YW'(LR);
    end
    rd_slot = SW'(sy);
  end

  always_comb begin
    if (acc_q > SAT_HI) begin
      sat_val  = 32'h7fffffff;
      sat_flag = 1'b1;
    end else if (acc_q < SAT_LO) begin
      sat_val  = 32'h80000000;
      sat_flag = 1'b1;
    end else begin
      sat_val  = 32'(acc_q);
      sat_flag = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i && (q_item_i.kind == KIND_PIXEL || q_item_i.kind == KIND_DRAIN)) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK:  state_d = ready ? ST_MAC : ST_IDLE;
      ST_MAC:    if (last_tap) state_d = ST_DRAIN;
      ST_DRAIN:  if (!rd_v_q && !prod_v_q) state_d = ST_RESULT;
      ST_RESULT: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    q_pop_o   = (state_q == ST_IDLE) && q_valid_i;
    do_pixel  = q_pop_o && (q_item_i.kind == KIND_PIXEL) && !frame_rcv_q;
    start_mac = (state_q == ST_CHECK) && ready;
    tap_issue = (state_q == ST_MAC);
    load_out  = (state_q == ST_RESULT) && out_free;
  end

  always_ff @(posedge clk_i) begin
    if (do_pixel) begin
      line_mem[{in_slot_q, in_col_q}] <= q_item_i.pixel;
    end
    if (q_pop_o && q_item_i.kind == KIND_COEF) begin
      coef_mem[KIW'(q_item_i.coef_idx)] <= COEF_BITS'(q_item_i.coef_val);
    end
    line_rd_q <= line_mem[{rd_slot, px}];
    coef_rd_q <= coef_mem[cidx_q];
    prod_q    <= $signed({1'b0, line_rd_q}) * coef_rd_q;
    if (load_out) begin
      m_axis_tdata <= {2'b00, 12'(pend_row_q), 10'(pend_col_q), sat_val};
      m_axis_tlast <= is_last;
      m_axis_tuser <= sat_flag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      width_q       <= WW'(W_RST);
      height_q      <= HW'(H_RST);
      rad_q         <= RDW'(1);
      in_col_q      <= '0;
      in_row_q      <= '0;
      in_slot_q     <= '0;
      pend_col_q    <= '0;
      pend_row_q    <= '0;
      pend_slot_q   <= '0;
      frame_rcv_q   <= 1'b0;
      ky_q          <= '0;
      kx_q          <= '0;
      cidx_q        <= '0;
      rd_v_q        <= 1'b0;
      prod_v_q      <= 1'b0;
      acc_q         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_v_q   <= tap_issue;
      prod_v_q <= rd_v_q;
      if (prod_v_q) acc_q <= acc_q + ACC_W'(prod_q);
      if (m_axis_tready) m_axis_tvalid <= 1'b0;

      if (do_pixel) begin
        if ({1'b0, in_col_q} == w_m1) begin
          in_col_q <= '0;
          if ({1'b0, in_row_q} == h_m1) begin
            in_row_q    <= '0;
            in_slot_q   <= '0;
            frame_rcv_q <= 1'b1;
          end else begin
            in_row_q  <= in_row_q + RW'(1);
            in_slot_q <= (in_slot_q == SW'(LR - 1)) ? '0 : in_slot_q + SW'(1);
          end
        end else begin
          in_col_q <= in_col_q + CW'(1);
        end
      end

      if (start_mac) begin
        ky_q   <= '0;
        kx_q   <= '0;
        cidx_q <= '0;
        acc_q  <= '0;
      end
      if (tap_issue) begin
        cidx_q <= cidx_q + KIW'(1);
        if (kx_q == side_m1) begin
          kx_q <= '0;
          ky_q <= ky_q + KW'(1);
        end else begin
          kx_q <= kx_q + KW'(1);
        end
      end

      if (load_out) begin
        m_axis_tvalid <= 1'b1;
        if (is_last) begin
          pend_col_q  <= '0;
          pend_row_q  <= '0;
          pend_slot_q <= '0;
          frame_rcv_q <= 1'b0;
        end else if ({1'b0, pend_col_q} == w_m1) begin
          pend_col_q  <= '0;
          pend_row_q  <= pend_row_q + RW'(1);
          pend_slot_q <= (pend_slot_q == SW'(LR - 1)) ? '0 : pend_slot_q + SW'(1);
        end else begin
          pend_col_q <= pend_col_q + CW'(1);
        end
      end

      // any register write restarts the stream; coefficients are kept
      if (cfg_we_i && (cfg_index_i == CFG_WIDTH || cfg_index_i == CFG_HEIGHT ||
                       cfg_index_i == CFG_RADIUS)) begin
        in_col_q    <= '0;
        in_row_q    <= '0;
        in_slot_q   <= '0;
        pend_col_q  <= '0;
        pend_row_q  <= '0;
        pend_slot_q <= '0;
        frame_rcv_q <= 1'b0;
        case (cfg_index_i)
          CFG_WIDTH: begin
            if (cfg_data_i[10:0] == 11'd0) width_q <= WW'(1);
            else if (32'(cfg_data_i[10:0]) > MAX_WIDTH) width_q <= WW'(MAX_WIDTH);
            else width_q <= WW'(cfg_data_i[10:0]);
          end
          CFG_HEIGHT: begin
            if (cfg_data_i == 13'd0) height_q <= HW'(1);
            else if (32'(cfg_data_i) > MAX_HEIGHT) height_q <= HW'(MAX_HEIGHT);
            else height_q <= HW'(cfg_data_i);
          end
          CFG_RADIUS: begin
            if (32'(cfg_data_i[1:0]) > MAX_RADIUS) rad_q <= RDW'(MAX_RADIUS);
            else rad_q <= RDW'(cfg_data_i[1:0]);
          end
          default: ;
        endcase
      end
    end
  end

  `ICRB_ASSERT_NEXT(a_result_loads_out, load_out, m_axis_tvalid)
  `ICRB_ASSERT_IMPLY(a_prod_follows_read, prod_v_q, $past(rd_v_q))
  `ICRB_ASSERT_IMPLY(a_slots_in_ring, 1'b1,
                     (32'(in_slot_q) < LR) && (32'(pend_slot_q) < LR))
  `ICRB_ASSERT_IMPLY(a_no_pop_while_busy, state_q != ST_IDLE, !q_pop_o)

endmodule
